// File: sv/letter_decimal_command_parser_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the letter/decimal command parser
// Helpers for concurrent checks in the RTL (used by lcp_core).
// ----------------------------------------------------------------------------
`ifndef LETTER_DECIMAL_COMMAND_PARSER_DEFINES_SVH
`define LETTER_DECIMAL_COMMAND_PARSER_DEFINES_SVH

// Same-cycle implication, disabled during reset
`define LCP_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset
`define LCP_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: sv/lcp_pkg.sv
// ----------------------------------------------------------------------------
// lcp_pkg
// Types, codes and the command letter lookup for the command parser.
// ----------------------------------------------------------------------------
package lcp_pkg;

  localparam int DIGIT_COUNT_DEFAULT = 3;
  localparam logic [15:0] INTERVAL_RESET = 16'd5100;
  localparam logic [15:0] AGE_MAX = 16'hFFFF;
  localparam logic [3:0] DUTY_INDEX = 4'd0;

  localparam logic MODE_BYTE = 1'b0;
  localparam logic MODE_TICK = 1'b1;

  // Command letters in table order
  localparam logic [7:0] CH_D_LOW  = 8'h64; // d
  localparam logic [7:0] CH_M_LOW  = 8'h6D; // m
  localparam logic [7:0] CH_E_UP   = 8'h45; // E
  localparam logic [7:0] CH_DOLLAR = 8'h24; // $
  localparam logic [7:0] CH_EQUAL  = 8'h3D; // =
  localparam logic [7:0] CH_C_UP   = 8'h43; // C
  localparam logic [7:0] CH_R_UP   = 8'h52; // R
  localparam logic [7:0] CH_E_LOW  = 8'h65; // e
  localparam logic [7:0] CH_F_LOW  = 8'h66; // f
  localparam logic [7:0] CH_ZERO   = 8'h30; // 0
  localparam logic [7:0] CH_NINE   = 8'h39; // 9

  typedef enum logic [1:0] {
    KIND_COMMAND   = 2'd0,
    KIND_MALFORMED = 2'd1,
    KIND_TIMEOUT   = 2'd2
  } lcp_kind_t;

  typedef struct packed {
    logic       mode;
    logic [7:0] rx_byte;
    logic       output_shorted;
  } lcp_item_t;

  typedef struct packed {
    lcp_kind_t  kind;
    logic [3:0] index;
    logic [7:0] value;
  } lcp_result_t;

  typedef struct packed {
    logic       hit;
    logic [3:0] index;
  } lcp_letter_t;

  // Map a byte to its command table position
  function automatic lcp_letter_t letter_lookup(input logic [7:0] b);
    lcp_letter_t r;
    r.hit = 1'b1;
    case (b)
      CH_D_LOW:  r.index = 4'd0;
      CH_M_LOW:  r.index = 4'd1;
      CH_E_UP:   r.index = 4'd2;
      CH_DOLLAR: r.index = 4'd3;
      CH_EQUAL:  r.index = 4'd4;
      CH_C_UP:   r.index = 4'd5;
      CH_R_UP:   r.index = 4'd6;
      CH_E_LOW:  r.index = 4'd7;
      CH_F_LOW:  r.index = 4'd8;
      default: begin
        r.hit   = 1'b0;
        r.index = 4'd0;
      end
    endcase
    return r;
  endfunction

endpackage

// File: sv/letter_decimal_command_parser.sv
// ----------------------------------------------------------------------------
// letter_decimal_command_parser
// Command letter plus decimal digits parser with a duty refresh watchdog.
//
//   Channel   Dir  Beat content
//   s_axis    in   tuser: mode; tdata: rx_byte, output_shorted
//   m_axis    out  tuser: result_kind; tdata: command_index, command_value
//   cfg       in   data: duty_refresh_interval_ms
//
// One item per cycle sustained while m_axis does not stall; a result passes
// from the input register through the core into the result register.
// Items that give no result leave nothing on m_axis.
// Synchronous active-high reset clears both stages and the parser state.
// A stalled m_axis holds the core; the input register still takes one beat.
// ----------------------------------------------------------------------------
module letter_decimal_command_parser
  import lcp_pkg::*;
#(
  parameter int DIGIT_COUNT = DIGIT_COUNT_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,  // [7:0] rx_byte, [8] output_shorted, rest zero
  input  logic [0:0]  s_axis_tuser,  // [0] mode
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,  // [3:0] command_index, [11:4] command_value, rest zero
  output logic [1:0]  m_axis_tuser,  // [1:0] result_kind
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data       // duty_refresh_interval_ms
);

  lcp_item_t   in_item;
  lcp_item_t   item;
  logic        item_valid;
  logic        advance;
  logic        out_free;
  logic        res_valid;
  lcp_result_t res;
  lcp_result_t out_res;

  // Unpack the input beat
  always_comb begin
    in_item.mode           = s_axis_tuser[0];
    in_item.rx_byte        = s_axis_tdata[7:0];
    in_item.output_shorted = s_axis_tdata[8];
  end

  assign cfg_ready = 1'b1;
  assign advance   = item_valid && out_free;

  lcp_in_stage u_in (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_axis_tvalid),
    .in_ready   (s_axis_tready),
    .in_item    (in_item),
    .item_valid (item_valid),
    .item       (item),
    .take       (advance)
  );

  lcp_core #(
    .DIGIT_COUNT (DIGIT_COUNT)
  ) u_core (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_value (cfg_data),
    .step      (advance),
    .item      (item),
    .res_valid (res_valid),
    .res       (res)
  );

  lcp_out_stage u_out (
    .clk       (clk),
    .rst       (rst),
    .load      (advance && res_valid),
    .load_res  (res),
    .free      (out_free),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_res   (out_res)
  );

  // Pack the result beat
  assign m_axis_tuser = out_res.kind;
  assign m_axis_tdata = {4'd0, out_res.value, out_res.index};

endmodule

// File: sv/lcp_in_stage.sv
// ----------------------------------------------------------------------------
// lcp_in_stage
// Input register: captures one beat and holds it until the core takes it.
// ----------------------------------------------------------------------------
module lcp_in_stage
  import lcp_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  lcp_item_t in_item,
  output logic      item_valid,
  output lcp_item_t item,
  input  logic      take
);

  // Accept when empty or when the held beat leaves this cycle
  assign in_ready = !item_valid || take;

  // Track occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (in_ready) begin
      item_valid <= in_valid;
    end
  end

  // Load payload
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item <= in_item;
    end
  end

endmodule

// File: sv/lcp_core.sv
// ----------------------------------------------------------------------------
// lcp_core
// Parser state, duty timer and interval register; one item per step.
// ----------------------------------------------------------------------------
`include "letter_decimal_command_parser_defines.svh"

module lcp_core
  import lcp_pkg::*;
#(
  parameter int DIGIT_COUNT = DIGIT_COUNT_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [15:0] cfg_value,
  input  logic        step,
  input  lcp_item_t   item,
  output logic        res_valid,
  output lcp_result_t res
);

  localparam int DW = $clog2(DIGIT_COUNT + 1);

  logic [15:0]   interval;
  logic          in_message, in_message_next;
  logic [3:0]    current_command, current_command_next;
  logic [DW-1:0] digits_seen, digits_seen_next;
  logic [7:0]    value_accumulator, value_accumulator_next;
  logic [15:0]   duty_age_ms, duty_age_ms_next;

  lcp_letter_t   letter;
  logic          is_digit;
  logic [7:0]    digit;
  logic [7:0]    acc_step;
  logic [15:0]   age_inc;
  logic          last_digit;

  // Decode the byte and precompute the next accumulator and age
  always_comb begin
    letter     = letter_lookup(item.rx_byte);
    is_digit   = (item.rx_byte >= CH_ZERO) && (item.rx_byte <= CH_NINE);
    digit      = item.rx_byte - CH_ZERO;
    acc_step   = {value_accumulator[4:0], 3'b000} + {value_accumulator[6:0], 1'b0} + digit;
    age_inc    = (duty_age_ms != AGE_MAX) ? duty_age_ms + 16'd1 : duty_age_ms;
    last_digit = (digits_seen == DW'(DIGIT_COUNT - 1));
  end

  // Next state and result
  always_comb begin
    in_message_next        = in_message;
    current_command_next   = current_command;
    digits_seen_next       = digits_seen;
    value_accumulator_next = value_accumulator;
    duty_age_ms_next       = duty_age_ms;
    res_valid              = 1'b0;
    res.kind               = KIND_COMMAND;
    res.index              = current_command;
    res.value              = 8'd0;

    if (item.mode == MODE_TICK) begin
      duty_age_ms_next = age_inc;
      if (!item.output_shorted && (interval != 16'd0) && (age_inc >= interval)) begin
        res_valid = 1'b1;
        res.kind  = KIND_TIMEOUT;
        res.index = DUTY_INDEX;
      end
    end else if (!in_message) begin
      if (letter.hit) begin
        in_message_next        = 1'b1;
        current_command_next   = letter.index;
        digits_seen_next       = '0;
        value_accumulator_next = 8'd0;
      end
    end else if (!is_digit) begin
      res_valid              = 1'b1;
      res.kind               = KIND_MALFORMED;
      in_message_next        = 1'b0;
      digits_seen_next       = '0;
      value_accumulator_next = 8'd0;
    end else if (last_digit) begin
      res_valid              = 1'b1;
      res.kind               = KIND_COMMAND;
      res.value              = acc_step;
      in_message_next        = 1'b0;
      digits_seen_next       = '0;
      value_accumulator_next = 8'd0;
      if (current_command == DUTY_INDEX) begin
        duty_age_ms_next = 16'd0;
      end
    end else begin
      digits_seen_next       = digits_seen + DW'(1);
      value_accumulator_next = acc_step;
    end
  end

  // Interval register
  always_ff @(posedge clk) begin
    if (rst) begin
      interval <= INTERVAL_RESET;
    end else if (cfg_we) begin
      interval <= cfg_value;
    end
  end

  // Advance parser state on each step
  always_ff @(posedge clk) begin
    if (rst) begin
      in_message        <= 1'b0;
      current_command   <= 4'd0;
      digits_seen       <= '0;
      value_accumulator <= 8'd0;
      duty_age_ms       <= 16'd0;
    end else if (step) begin
      in_message        <= in_message_next;
      current_command   <= current_command_next;
      digits_seen       <= digits_seen_next;
      value_accumulator <= value_accumulator_next;
      duty_age_ms       <= duty_age_ms_next;
    end
  end

  `LCP_ASSERT_NEXT(a_complete_goes_idle, clk, rst,
    step && res_valid && (res.kind == KIND_COMMAND), !in_message,
    "parser still in a message after a completed command")

  `LCP_ASSERT_NEXT(a_duty_clears_age, clk, rst,
    step && res_valid && (res.kind == KIND_COMMAND) && (res.index == DUTY_INDEX),
    duty_age_ms == 16'd0, "duty command did not clear the timer")

  `LCP_ASSERT_IMP(a_timeout_only_on_tick, clk, rst,
    res_valid && (res.kind == KIND_TIMEOUT), item.mode == MODE_TICK,
    "timeout raised on a byte item")

  `LCP_ASSERT_IMP(a_digits_in_range, clk, rst,
    1'b1, digits_seen < DW'(DIGIT_COUNT), "digit count out of range")

endmodule

// File: sv/lcp_out_stage.sv
// ----------------------------------------------------------------------------
// lcp_out_stage
// Result register: holds one result beat until the sink takes it.
// ----------------------------------------------------------------------------
module lcp_out_stage
  import lcp_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        load,
  input  lcp_result_t load_res,
  output logic        free,
  output logic        out_valid,
  input  logic        out_ready,
  output lcp_result_t out_res
);

  // Room for a new result when empty or draining this cycle
  assign free = !out_valid || out_ready;

  // Track occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (free) begin
      out_valid <= load;
    end
  end

  // Load payload
  always_ff @(posedge clk) begin
    if (load && free) begin
      out_res <= load_res;
    end
  end

endmodule

// File: tb/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the command letter plus decimal digits parser.
// Drives received bytes and millisecond ticks on s_axis and predicts every
// m_axis beat from a behavioral copy of the parser and the duty timer.
// Traffic is mostly well-formed letter-plus-three-digit messages with ticks
// mixed in, plus broken messages and noise. It runs under several refresh
// intervals.
// ----------------------------------------------------------------------------
module tb;
  import lcp_pkg::*;

  localparam int DIGITS        = DIGIT_COUNT_DEFAULT;
  localparam int SETTLE_CYCLES = 10;
  localparam int STALL_LIMIT   = 2000;
  localparam int PHASE_ITEMS   = 200;

  localparam logic [7:0] LETTERS [9] = '{
    CH_D_LOW, CH_M_LOW, CH_E_UP, CH_DOLLAR, CH_EQUAL,
    CH_C_UP, CH_R_UP, CH_E_LOW, CH_F_LOW
  };

  // Behavioral parser and duty timer, plus the queue of results still owed
  class lcp_scoreboard;
    logic [15:0] interval;
    bit          busy;
    logic [3:0]  cmd;
    int          ndigits;
    logic [7:0]  acc;
    logic [15:0] age;
    lcp_result_t owed_q[$];
    int          errors;
    int          n_items;
    int          n_cmds;
    int          n_malformed;
    int          n_timeouts;

    function new();
      interval    = INTERVAL_RESET;
      busy        = 1'b0;
      cmd         = '0;
      ndigits     = 0;
      acc         = '0;
      age         = '0;
      errors      = 0;
      n_items     = 0;
      n_cmds      = 0;
      n_malformed = 0;
      n_timeouts  = 0;
    endfunction

    function void set_interval(input logic [15:0] v);
      interval = v;
    endfunction

    function int pending();
      return owed_q.size();
    endfunction

    function void owe(input lcp_kind_t k, input logic [3:0] idx, input logic [7:0] val);
      lcp_result_t r;
      r.kind  = k;
      r.index = idx;
      r.value = val;
      owed_q.push_back(r);
    endfunction

    // Advance the parser by one accepted input beat
    function void note_item(input logic mode, input logic [7:0] b, input logic sh);
      bit hit;
      hit = 1'b0;
      n_items++;
      if (mode == MODE_TICK) begin
        if (age != AGE_MAX) age = age + 16'd1;
        if (!sh && interval != 16'd0 && age >= interval) begin
          owe(KIND_TIMEOUT, DUTY_INDEX, 8'd0);
          n_timeouts++;
        end
      end else if (!busy) begin
        // open a message on a command letter, drop anything else
        for (int i = 0; i < 9; i++) begin
          if (b == LETTERS[i]) begin
            hit = 1'b1;
            cmd = 4'(i);
          end
        end
        if (hit) begin
          busy    = 1'b1;
          ndigits = 0;
          acc     = '0;
        end
      end else if (b < CH_ZERO || b > CH_NINE) begin
        owe(KIND_MALFORMED, cmd, 8'd0);
        n_malformed++;
        busy    = 1'b0;
        ndigits = 0;
        acc     = '0;
      end else begin
        acc = 8'(acc * 10 + (b - CH_ZERO));
        ndigits++;
        if (ndigits >= DIGITS) begin
          owe(KIND_COMMAND, cmd, acc);
          n_cmds++;
          if (cmd == DUTY_INDEX) age = '0;
          busy    = 1'b0;
          ndigits = 0;
          acc     = '0;
        end
      end
    endfunction

    // Compare one output beat with the oldest owed result
    function void check_result(input logic [1:0] k, input logic [3:0] idx,
                               input logic [7:0] val);
      lcp_result_t r;
      if (owed_q.size() == 0) begin
        $error("unexpected result beat: kind %0d index %0d value %0d", k, idx, val);
        errors++;
        return;
      end
      r = owed_q.pop_front();
      if (k !== r.kind) begin
        $error("result_kind: expected %0d, got %0d", r.kind, k);
        errors++;
      end
      if (idx !== r.index) begin
        $error("command_index: expected %0d, got %0d", r.index, idx);
        errors++;
      end
      if (val !== r.value) begin
        $error("command_value: expected %0d, got %0d", r.value, val);
        errors++;
      end
    endfunction
  endclass

  logic        clk;
  logic        rst           = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata  = '0;
  logic [0:0]  s_axis_tuser  = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;
  logic        cfg_valid     = 1'b0;
  logic        cfg_ready;
  logic [15:0] cfg_data      = '0;

  lcp_scoreboard sb = new();
  bit            no_idle    = 1'b0;
  int            n_settings = 0;
  int            idle_cycles = 0;

  letter_decimal_command_parser u_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),   // [7:0] rx_byte, [8] output_shorted
    .s_axis_tuser  (s_axis_tuser),   // [0] mode
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),   // [3:0] command_index, [11:4] command_value
    .m_axis_tuser  (m_axis_tuser),   // [1:0] result_kind
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Note accepted input beats and check accepted output beats
  always @(posedge clk) begin
    if (!rst) begin
      if (s_axis_tvalid && s_axis_tready)
        sb.note_item(s_axis_tuser[0], s_axis_tdata[7:0], s_axis_tdata[8]);
      if (m_axis_tvalid && m_axis_tready)
        sb.check_result(m_axis_tuser, m_axis_tdata[3:0], m_axis_tdata[11:4]);
    end
  end

  // Abort when no channel moves a beat for too long
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Output side: stall a random number of cycles before each beat
  initial begin : rx_side
    int stall;
    forever begin
      stall = no_idle ? 0 : $urandom_range(0, 19);
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk); while (!(m_axis_tvalid === 1'b1 && !rst));
    end
  end

  // Send one beat; valid stays high afterwards unless a gap follows
  task automatic send_item(input logic mode, input logic [7:0] b, input logic sh);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 19);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= mode;
    s_axis_tdata  <= {7'd0, sh, b};
    do @(posedge clk); while (!s_axis_tready);
  endtask

  task automatic send_byte(input logic [7:0] b);
    send_item(MODE_BYTE, b, 1'($urandom_range(0, 1)));
  endtask

  task automatic send_tick(input logic sh);
    send_item(MODE_TICK, 8'($urandom_range(0, 255)), sh);
  endtask

  task automatic send_digits(input int n);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 9) == 0) send_tick($urandom_range(0, 3) == 0);
      send_byte(CH_ZERO + 8'($urandom_range(0, 9)));
    end
  endtask

  // Wait until every owed result is out, then let the pipeline empty
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_interval(input logic [15:0] v);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    sb.set_interval(v);
    n_settings++;
  endtask

  // Random traffic, weighted toward complete messages
  task automatic run_traffic(input int n);
    int target;
    int pick;
    int idx;
    logic [7:0] b;
    target = sb.n_items + n;
    while (sb.n_items < target) begin
      pick = $urandom_range(0, 99);
      idx  = $urandom_range(0, 11);
      if (idx > 8) idx = 0;
      if (pick < 55) begin
        send_byte(LETTERS[idx]);
        send_digits(DIGITS);
      end else if (pick < 70) begin
        send_byte(LETTERS[idx]);
        send_digits($urandom_range(0, DIGITS - 1));
        do b = 8'($urandom_range(0, 255)); while (b >= CH_ZERO && b <= CH_NINE);
        send_byte(b);
      end else if (pick < 85) begin
        repeat ($urandom_range(1, 6)) send_tick($urandom_range(0, 3) == 0);
      end else begin
        send_byte(8'($urandom_range(0, 255)));
      end
    end
  endtask

  initial begin : stimulus
    logic [15:0] settings [7];
    settings = '{16'd1, 16'd0, 16'd4, 16'hFFFF, 16'd12, 16'd40, 16'd2};
    settings[6] = 16'($urandom_range(2, 25));

    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: value extremes, wrap, commands and malformed messages, idle noise
    send_byte(CH_D_LOW);
    send_byte(CH_ZERO + 8'd2); send_byte(CH_ZERO + 8'd5); send_byte(CH_ZERO + 8'd5);
    send_byte(CH_M_LOW);
    send_byte(CH_NINE); send_byte(CH_NINE); send_byte(CH_NINE);
    send_tick(1'b0);
    send_byte(CH_E_UP);
    send_byte(CH_ZERO); send_byte(CH_ZERO); send_byte(CH_ZERO);
    send_tick(1'b1);
    send_byte(CH_DOLLAR); send_byte(CH_ZERO + 8'd1); send_byte(8'hFF);
    send_byte(8'h00);
    send_byte(CH_EQUAL); send_byte(CH_ZERO - 8'd1);
    send_byte(CH_C_UP); send_byte(CH_NINE + 8'd1);
    send_byte(8'hFF);
    drain();

    // Random phases, one refresh interval each
    for (int p = 0; p < 7; p++) begin
      no_idle = (p == 2);
      write_interval(settings[p]);
      run_traffic(PHASE_ITEMS);
      drain();
    end

    $display("Run covered %0d items under %0d interval settings", sb.n_items, n_settings);
    $display("Results seen: %0d commands, %0d malformed, %0d timeouts",
             sb.n_cmds, sb.n_malformed, sb.n_timeouts);
    if (sb.errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// File: filelist.f
+incdir+sv
sv/lcp_pkg.sv
sv/lcp_in_stage.sv
sv/lcp_core.sv
sv/lcp_out_stage.sv
sv/letter_decimal_command_parser.sv
tb/tb.sv
